### sv/sdes_pkg.sv
`default_nettype none

package sdes_pkg;

	// Bit positions count from one at the most significant bit
	localparam int P10 [10] = '{3, 5, 2, 7, 4, 10, 1, 9, 8, 6};
	localparam int P8 [8] = '{6, 3, 7, 4, 8, 5, 10, 9};
	localparam int IP [8] = '{2, 6, 3, 1, 4, 8, 5, 7};
	localparam int IP_INV [8] = '{4, 1, 3, 5, 7, 2, 8, 6};
	localparam int EP [8] = '{4, 1, 2, 3, 2, 3, 4, 1};
	localparam int P4 [4] = '{2, 4, 3, 1};

	localparam logic [1:0] SBOX_A [4][4] = '{
		'{2'd1, 2'd0, 2'd3, 2'd2},
		'{2'd3, 2'd2, 2'd1, 2'd0},
		'{2'd0, 2'd2, 2'd1, 2'd3},
		'{2'd3, 2'd1, 2'd0, 2'd2}
	};
	localparam logic [1:0] SBOX_B [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd2, 2'd3, 2'd1, 2'd0},
		'{2'd3, 2'd0, 2'd1, 2'd2},
		'{2'd2, 2'd1, 2'd0, 2'd3}
	};

	// Register map
	localparam logic REG_CIPHER_KEY = 1'b0;

	typedef struct packed {
		logic [7:0] k1;
		logic [7:0] k2;
	} sdes_subkeys_t;

	function automatic logic [9:0] perm_p10(input logic [9:0] v);
		logic [9:0] r;
		for (int i = 0; i < 10; i++) begin
			r[9 - i] = v[10 - P10[i]];
		end
		return r;
	endfunction

	function automatic logic [7:0] perm_p8(input logic [9:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7 - i] = v[10 - P8[i]];
		end
		return r;
	endfunction

	function automatic logic [7:0] perm_ip(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7 - i] = v[8 - IP[i]];
		end
		return r;
	endfunction

	function automatic logic [7:0] perm_ip_inv(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7 - i] = v[8 - IP_INV[i]];
		end
		return r;
	endfunction

	function automatic logic [7:0] perm_ep(input logic [3:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7 - i] = v[4 - EP[i]];
		end
		return r;
	endfunction

	function automatic logic [3:0] perm_p4(input logic [3:0] v);
		logic [3:0] r;
		for (int i = 0; i < 4; i++) begin
			r[3 - i] = v[4 - P4[i]];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### sv/sdes_keysched.sv
`default_nettype none

module sdes_keysched (
	input  wire logic [9:0]           cipher_key,
	output sdes_pkg::sdes_subkeys_t   subkeys
);

	logic [9:0] p10;
	logic [9:0] rot1;
	logic [9:0] rot2;

	// Permute the key, then rotate each five-bit half from the same start
	always_comb begin
		p10 = sdes_pkg::perm_p10(cipher_key);
		rot1 = {p10[8:5], p10[9], p10[3:0], p10[4]};
		rot2 = {p10[7:5], p10[9:8], p10[2:0], p10[4:3]};
		subkeys.k1 = sdes_pkg::perm_p8(rot1);
		subkeys.k2 = sdes_pkg::perm_p8(rot2);
	end

endmodule

`default_nettype wire

### sv/sdes_round.sv
`default_nettype none

module sdes_round (
	input  wire logic [3:0] left,
	input  wire logic [3:0] right,
	input  wire logic [7:0] subkey,
	output logic      [3:0] left_next
);

	logic [7:0] mixed;
	logic [1:0] s_a;
	logic [1:0] s_b;

	// Expand, mix in the subkey, substitute, permute, fold into the left half
	always_comb begin
		mixed = sdes_pkg::perm_ep(right) ^ subkey;
		s_a = sdes_pkg::SBOX_A[{mixed[7], mixed[4]}][mixed[6:5]];
		s_b = sdes_pkg::SBOX_B[{mixed[3], mixed[0]}][mixed[2:1]];
		left_next = left ^ sdes_pkg::perm_p4({s_a, s_b});
	end

endmodule

`default_nettype wire

### sv/simplified_des_cipher_unit.sv
`default_nettype none

// Channel   Handshake                           Payload
// command   start in, busy out (always low)      cmd, data_in
// result    done out, one-cycle strobe           data_out
// config    APB: psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// One block is taken every cycle; after the transfer, the block is held in
// the input register, then passes through the two Feistel rounds into the
// result register, which drives the strobe.
// Reset clears the key and both valid flags.
// The receiver cannot stall; busy never rises.

module simplified_des_cipher_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cmd,
	input  wire logic [7:0]  data_in,
	output logic             done,
	output logic      [7:0]  data_out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	logic [9:0]              cipher_key_q;
	logic                    valid_s1;
	logic                    cmd_s1;
	logic [7:0]              data_s1;
	logic                    valid_s2;
	logic [7:0]              data_s2;
	sdes_pkg::sdes_subkeys_t subkeys;
	logic [7:0]              ip;
	logic [7:0]              key_a;
	logic [7:0]              key_b;
	logic [3:0]              r1;
	logic [3:0]              l2;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	// Write the key register on a completed APB write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_key_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == sdes_pkg::REG_CIPHER_KEY) begin
			cipher_key_q <= pwdata[9:0];
		end
	end

	// Read back the key
	always_comb begin
		prdata = '0;
		if (paddr[2] == sdes_pkg::REG_CIPHER_KEY) begin
			prdata = {22'd0, cipher_key_q};
		end
	end

	sdes_keysched u_keysched (
		.cipher_key (cipher_key_q),
		.subkeys    (subkeys)
	);

	// Capture each command transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1  <= cmd;
			data_s1 <= data_in;
		end
	end

	// Swap subkey order for decrypt
	always_comb begin
		ip    = sdes_pkg::perm_ip(data_s1);
		key_a = cmd_s1 ? subkeys.k2 : subkeys.k1;
		key_b = cmd_s1 ? subkeys.k1 : subkeys.k2;
	end

	sdes_round u_round1 (
		.left      (ip[7:4]),
		.right     (ip[3:0]),
		.subkey    (key_a),
		.left_next (r1)
	);

	sdes_round u_round2 (
		.left      (ip[3:0]),
		.right     (r1),
		.subkey    (key_b),
		.left_next (l2)
	);

	// Register the result and its strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			data_s2 <= sdes_pkg::perm_ip_inv({l2, r1});
		end
	end

	assign done     = valid_s2;
	assign data_out = data_s2;

endmodule

`default_nettype wire

### sv/sdes_checker.sv
`default_nettype none

module sdes_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        cmd,
	input wire logic [7:0]  data_in,
	input wire logic        done,
	input wire logic [7:0]  data_out,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [2:0]  paddr,
	input wire logic [31:0] pwdata,
	input wire logic [31:0] prdata
);

	// Every transfer yields a result strobe
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("result missing after command transfer");

	// No result without a transfer
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> ##1 !done)
		else $error("result strobe without command transfer");

	// Equal back-to-back commands under the same key give equal results
	a_repeat_same: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) ##1 (start && !busy && $stable(cmd) && $stable(data_in)
			&& !(psel && penable && pwrite)) |=> ##1 (done && $stable(data_out)))
		else $error("same command and key gave different results");

	// Key written reads back
	a_key_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2] == sdes_pkg::REG_CIPHER_KEY) |=>
			(paddr[2] != sdes_pkg::REG_CIPHER_KEY
				|| prdata == {22'd0, $past(pwdata[9:0])}))
		else $error("key readback mismatch");

endmodule

bind simplified_des_cipher_unit sdes_checker u_sdes_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.cmd      (cmd),
	.data_in  (data_in),
	.done     (done),
	.data_out (data_out),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata)
);

`default_nettype wire
